// ----- rtl/row_table_insert_remove_assert.svh -----
// Assertion macros for the row table block.
// Define NO_ASSERTIONS to compile every check away; no other dependency.
`ifndef ROW_TABLE_INSERT_REMOVE_ASSERT_SVH
`define ROW_TABLE_INSERT_REMOVE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check that is switched off while reset is held.
`define RTI_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("row table check failed");
// Check that holds in and out of reset.
`define RTI_ASSERT_ON(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("row table invariant failed");
`else
`define RTI_ASSERT(lbl, clk, rstn, prop)
`define RTI_ASSERT_ON(lbl, clk, prop)
`endif
`endif

// ----- rtl/rti_pkg.sv -----
// Shared types and constants of the row table block.
// No dependencies; the files that use it refer to it by scoped names.
package rti_pkg;

    localparam int ROW_W   = 7;
    localparam int COL_W   = 3;
    localparam int NCOLS_W = 4;
    localparam int VAL_W   = 32;
    localparam int FILL_VALUE = -3;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_WRITE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } st_t;

    typedef enum logic [1:0] {
        SRC_SHIFT = 2'd0,
        SRC_ROW   = 2'd1,
        SRC_ELEM  = 2'd2
    } wr_src_t;

    typedef struct packed {
        cmd_t                    cmd;
        logic [ROW_W-1:0]        row_index;
        logic [COL_W-1:0]        col_index;
        logic signed [VAL_W-1:0] value_0;
        logic signed [VAL_W-1:0] value_1;
        logic signed [VAL_W-1:0] value_2;
        logic signed [VAL_W-1:0] value_3;
        logic signed [VAL_W-1:0] value_4;
        logic signed [VAL_W-1:0] value_5;
        logic signed [VAL_W-1:0] value_6;
        logic signed [VAL_W-1:0] value_7;
    } req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        st_t                     status;
        logic [ROW_W-1:0]        row_count;
    } rsp_t;

    // Write control broadcast from the sequencer to every lane.
    typedef struct packed {
        logic               en;
        wr_src_t            src;
        logic [COL_W-1:0]   col;
        logic [NCOLS_W-1:0] live;
    } lane_ctl_t;

    // Finished request handed to the merge stage.
    typedef struct packed {
        logic             valid;
        cmd_t             cmd;
        st_t              status;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] count;
    } done_t;

endpackage

// ----- rtl/rti_req_if.sv -----
// Request channel of the row table block: valid, ready and one request.
// Depends on rti_pkg for the payload type.
interface rti_req_if;
    logic          valid;
    logic          ready;
    rti_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/rti_rsp_if.sv -----
// Response channel of the row table block: valid, ready and one result.
// Depends on rti_pkg for the payload type.
interface rti_rsp_if;
    logic          valid;
    logic          ready;
    rti_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/rti_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module rti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/rti_lane.sv -----
// One column lane: holds its column of every row in a RAM and picks write data.
// Depends on rti_pkg and rti_ram.
module rti_lane #(
    parameter int LANE       = 0,
    parameter int MAX_ROWS   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                take,
    input  logic signed [rti_pkg::VAL_W-1:0]    in_val,
    input  rti_pkg::lane_ctl_t                  ctl,
    input  logic [$clog2(MAX_ROWS)-1:0]         rd_addr,
    input  logic [$clog2(MAX_ROWS)-1:0]         wr_addr,
    output logic [DATA_WIDTH-1:0]               rd_data
);

    localparam logic [DATA_WIDTH-1:0] FILL = DATA_WIDTH'(rti_pkg::FILL_VALUE);

    logic [DATA_WIDTH-1:0] val_reg;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  wr_en;

    // Capture this lane's value with the request; truncate or sign-extend.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            val_reg <= DATA_WIDTH'(in_val);
        end
    end

    always_comb
    begin
        case (ctl.src)
            rti_pkg::SRC_SHIFT: wr_data = rd_data;
            rti_pkg::SRC_ROW:   wr_data = (rti_pkg::NCOLS_W'(LANE) < ctl.live) ? val_reg : FILL;
            rti_pkg::SRC_ELEM:  wr_data = val_reg;
            default:            wr_data = val_reg;
        endcase
        wr_en = ctl.en &&
                ((ctl.src != rti_pkg::SRC_ELEM) || (ctl.col == rti_pkg::COL_W'(LANE)));
    end

    rti_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MAX_ROWS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

// ----- rtl/rti_seq.sv -----
// Request sequencer: range checks, row count, column register and row moves.
// Depends on rti_pkg, rti_req_if and the assertion macro header.
`include "row_table_insert_remove_assert.svh"
module rti_seq #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [rti_pkg::NCOLS_W-1:0]         cfg_wr_data,
    rti_req_if.sink                             req,
    output logic                                take,
    output rti_pkg::lane_ctl_t                  ctl,
    output logic [$clog2(MAX_ROWS)-1:0]         rd_addr,
    output logic [$clog2(MAX_ROWS)-1:0]         wr_addr,
    output rti_pkg::done_t                      done,
    input  logic                                done_ready
);

    localparam int AW   = $clog2(MAX_ROWS);
    localparam int CW   = $clog2(MAX_ROWS + 1);
    localparam int CMPW = (CW > rti_pkg::ROW_W) ? CW : rti_pkg::ROW_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_WRITE = 6'b000100,
        S_SHIFT = 6'b001000,
        S_FILL  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t                       state_reg, state_next;
    logic [CW-1:0]                total_reg, total_next;
    logic [rti_pkg::NCOLS_W-1:0]  ncols_reg;
    rti_pkg::cmd_t                cmd_reg, cmd_next;
    rti_pkg::st_t                 status_reg, status_next;
    logic [AW-1:0]                row_reg, row_next;
    logic [rti_pkg::COL_W-1:0]    col_reg, col_next;
    logic [AW-1:0]                ptr_reg, ptr_next;
    logic [AW-1:0]                prev_reg, prev_next;
    logic [CW-1:0]                left_reg, left_next;
    logic                         pend_reg, pend_next;

    logic [rti_pkg::NCOLS_W-1:0]  live;
    logic [CMPW-1:0]              row_x;
    logic [CMPW-1:0]              tot_x;
    rti_pkg::st_t                 acc_status;

    assign row_x = CMPW'(req.data.row_index);
    assign tot_x = CMPW'(total_reg);

    // Clamp the column register to 1..MAX_COLS.
    always_comb
    begin
        live = ncols_reg;
        if (ncols_reg == '0)
        begin
            live = rti_pkg::NCOLS_W'(1);
        end
        else if (ncols_reg > rti_pkg::NCOLS_W'(MAX_COLS))
        begin
            live = rti_pkg::NCOLS_W'(MAX_COLS);
        end
    end

    // Index checks; a range error wins over a full table.
    always_comb
    begin
        acc_status = rti_pkg::ST_OK;
        case (req.data.cmd) inside
            rti_pkg::CMD_INSERT:
            begin
                if (row_x > tot_x)
                begin
                    acc_status = rti_pkg::ST_RANGE;
                end
                else if (tot_x == CMPW'(MAX_ROWS))
                begin
                    acc_status = rti_pkg::ST_FULL;
                end
            end
            rti_pkg::CMD_REMOVE:
            begin
                if (row_x >= tot_x)
                begin
                    acc_status = rti_pkg::ST_RANGE;
                end
            end
            rti_pkg::CMD_READ, rti_pkg::CMD_WRITE:
            begin
                if ((row_x >= tot_x) ||
                    (rti_pkg::NCOLS_W'(req.data.col_index) >= live))
                begin
                    acc_status = rti_pkg::ST_RANGE;
                end
            end
            default: acc_status = rti_pkg::ST_RANGE;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        total_next  = total_reg;
        cmd_next    = cmd_reg;
        status_next = status_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        ptr_next    = ptr_reg;
        prev_next   = prev_reg;
        left_next   = left_reg;
        pend_next   = pend_reg;
        take        = 1'b0;
        ctl.en      = 1'b0;
        ctl.src     = rti_pkg::SRC_SHIFT;
        ctl.col     = col_reg;
        ctl.live    = live;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    take        = 1'b1;
                    cmd_next    = req.data.cmd;
                    status_next = acc_status;
                    row_next    = AW'(row_x);
                    col_next    = req.data.col_index;
                    pend_next   = 1'b0;
                    if (acc_status != rti_pkg::ST_OK)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        case (req.data.cmd)
                            rti_pkg::CMD_INSERT:
                            begin
                                total_next = CW'(tot_x + CMPW'(1));
                                if (row_x == tot_x)
                                begin
                                    state_next = S_FILL;
                                end
                                else
                                begin
                                    state_next = S_SHIFT;
                                    ptr_next   = AW'(tot_x - CMPW'(1));
                                    left_next  = CW'(tot_x - row_x);
                                end
                            end
                            rti_pkg::CMD_REMOVE:
                            begin
                                total_next = CW'(tot_x - CMPW'(1));
                                if ((row_x + CMPW'(1)) == tot_x)
                                begin
                                    state_next = S_DONE;
                                end
                                else
                                begin
                                    state_next = S_SHIFT;
                                    ptr_next   = AW'(row_x + CMPW'(1));
                                    left_next  = CW'(tot_x - row_x - CMPW'(1));
                                end
                            end
                            rti_pkg::CMD_READ:  state_next = S_READ;
                            rti_pkg::CMD_WRITE: state_next = S_WRITE;
                            default:            state_next = S_DONE;
                        endcase
                    end
                end
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_WRITE:
            begin
                ctl.en     = 1'b1;
                ctl.src    = rti_pkg::SRC_ELEM;
                state_next = S_DONE;
            end
            S_SHIFT:
            begin
                // Read one row ahead, write the row read last cycle.
                ctl.en  = pend_reg;
                ctl.src = rti_pkg::SRC_SHIFT;
                if (left_reg != '0)
                begin
                    ptr_next  = (cmd_reg == rti_pkg::CMD_INSERT) ? ptr_reg - 1'b1
                                                                 : ptr_reg + 1'b1;
                    prev_next = ptr_reg;
                    left_next = left_reg - 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = (cmd_reg == rti_pkg::CMD_INSERT) ? S_FILL : S_DONE;
                end
            end
            S_FILL:
            begin
                ctl.en     = 1'b1;
                ctl.src    = rti_pkg::SRC_ROW;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (done_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rd_addr  = (state_reg == S_SHIFT) ? ptr_reg : row_reg;

    always_comb
    begin
        if (state_reg == S_SHIFT)
        begin
            wr_addr = (cmd_reg == rti_pkg::CMD_INSERT) ? prev_reg + 1'b1 : prev_reg - 1'b1;
        end
        else
        begin
            wr_addr = row_reg;
        end
    end

    assign req.ready   = (state_reg == S_IDLE);
    assign done.valid  = (state_reg == S_DONE);
    assign done.cmd    = cmd_reg;
    assign done.status = status_reg;
    assign done.col    = col_reg;
    assign done.count  = tot_x[rti_pkg::ROW_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            total_reg <= '0;
            ncols_reg <= rti_pkg::NCOLS_W'(MAX_COLS);
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            pend_reg  <= pend_next;
            if (cfg_wr_en)
            begin
                ncols_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        status_reg <= status_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        ptr_reg    <= ptr_next;
        prev_reg   <= prev_next;
        left_reg   <= left_next;
    end

    `RTI_ASSERT_ON(a_reset_idle, clk, (!rst_n) |=> (state_reg == S_IDLE && total_reg == '0))
    `RTI_ASSERT(a_count_bound, clk, rst_n, (total_reg <= CW'(MAX_ROWS)))
    `RTI_ASSERT(a_shift_no_collide, clk, rst_n,
        (state_reg == S_SHIFT && pend_reg && left_reg != '0) |-> (wr_addr != rd_addr))
    `RTI_ASSERT(a_insert_count, clk, rst_n,
        (take && req.data.cmd == rti_pkg::CMD_INSERT && acc_status == rti_pkg::ST_OK)
        |=> (total_reg == CW'($past(total_reg) + 1'b1)))
    `RTI_ASSERT(a_reject_hold, clk, rst_n,
        (take && acc_status != rti_pkg::ST_OK) |=> $stable(total_reg))
    `RTI_ASSERT(a_done_hold, clk, rst_n,
        (state_reg == S_DONE && !done_ready) |=> (state_reg == S_DONE))

endmodule

// ----- rtl/rti_merge.sv -----
// Merge stage: picks the addressed lane, builds the result, holds it in a register.
// Depends on rti_pkg and rti_rsp_if.
module rti_merge #(
    parameter int MAX_COLS   = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rti_pkg::done_t        done,
    output logic                  done_ready,
    input  logic [DATA_WIDTH-1:0] lane_rd [MAX_COLS],
    rti_rsp_if.source             rsp
);

    logic [DATA_WIDTH-1:0]            sel;
    logic signed [rti_pkg::VAL_W-1:0] rd_ext;
    logic                             load;
    logic                             out_valid_reg;
    logic signed [rti_pkg::VAL_W-1:0] read_value_reg;
    rti_pkg::st_t                     status_reg;
    logic [rti_pkg::ROW_W-1:0]        count_reg;

    always_comb
    begin
        sel = '0;
        for (int c = 0; c < MAX_COLS; c++)
        begin
            if (done.col == rti_pkg::COL_W'(c))
            begin
                sel = lane_rd[c];
            end
        end
        rd_ext = rti_pkg::VAL_W'(signed'(sel));
    end

    assign done_ready = !out_valid_reg || rsp.ready;
    assign load       = done.valid && done_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            read_value_reg <= (done.cmd == rti_pkg::CMD_READ && done.status == rti_pkg::ST_OK)
                              ? rd_ext : '0;
            status_reg     <= done.status;
            count_reg      <= done.count;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.data.read_value = read_value_reg;
    assign rsp.data.status     = status_reg;
    assign rsp.data.row_count  = count_reg;

endmodule

// ----- rtl/row_table_insert_remove.sv -----
// Top level of the row table: sequencer, one RAM lane per column, merge stage.
// Depends on rti_pkg, rti_req_if, rti_rsp_if, rti_seq, rti_lane and rti_merge.
//
//   channel   dir  handshake          payload
//   req       in   valid/ready        cmd, row_index, col_index, value_0..value_7
//   rsp       out  valid/ready        read_value, status, row_count
//   cfg       in   cfg_wr_en          cfg_wr_data = ncols
//
// One request at a time; the row moves run one row per cycle through each lane's
// RAM. A new request is taken while the previous result still waits in the output
// register. Reset clears the row count, not the rows; rows above the count are
// never read, so no clearing pass runs. A stalled result holds the sequencer in
// its final state.
module row_table_insert_remove #(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [rti_pkg::NCOLS_W-1:0] cfg_wr_data,
    rti_req_if.sink                     req,
    rti_rsp_if.source                   rsp
);

    localparam int AW = $clog2(MAX_ROWS);

    logic                             take;
    rti_pkg::lane_ctl_t               ctl;
    logic [AW-1:0]                    rd_addr;
    logic [AW-1:0]                    wr_addr;
    rti_pkg::done_t                   done;
    logic                             done_ready;
    logic signed [rti_pkg::VAL_W-1:0] vals [8];
    logic [DATA_WIDTH-1:0]            lane_rd [MAX_COLS];

    always_comb
    begin
        vals[0] = req.data.value_0;
        vals[1] = req.data.value_1;
        vals[2] = req.data.value_2;
        vals[3] = req.data.value_3;
        vals[4] = req.data.value_4;
        vals[5] = req.data.value_5;
        vals[6] = req.data.value_6;
        vals[7] = req.data.value_7;
    end

    rti_seq #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .take        (take),
        .ctl         (ctl),
        .rd_addr     (rd_addr),
        .wr_addr     (wr_addr),
        .done        (done),
        .done_ready  (done_ready)
    );

    for (genvar c = 0; c < MAX_COLS; c++)
    begin : g_lane
        logic signed [rti_pkg::VAL_W-1:0] lane_in;

        // An element write carries its value in value_0 for every lane.
        assign lane_in = (req.data.cmd == rti_pkg::CMD_WRITE) ? vals[0] : vals[c];

        rti_lane #(
            .LANE       (c),
            .MAX_ROWS   (MAX_ROWS),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_lane (
            .clk     (clk),
            .take    (take),
            .in_val  (lane_in),
            .ctl     (ctl),
            .rd_addr (rd_addr),
            .wr_addr (wr_addr),
            .rd_data (lane_rd[c])
        );
    end

    rti_merge #(
        .MAX_COLS   (MAX_COLS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .done       (done),
        .done_ready (done_ready),
        .lane_rd    (lane_rd),
        .rsp        (rsp)
    );

endmodule

// ----- test/row_table_insert_remove_tb.sv -----
// Testbench for row_table_insert_remove: self-checking, with a row table predictor.
// Depends on rti_pkg, rti_req_if, rti_rsp_if and the row_table_insert_remove RTL.
module row_table_insert_remove_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_ROWS  = 64;
    localparam int TABLE_COLS  = 8;
    localparam int IDLE_LIMIT  = 3000;
    localparam int SETTLE_WAIT = 80;
    localparam logic [rti_pkg::VAL_W-1:0] FILL_BITS = rti_pkg::VAL_W'(rti_pkg::FILL_VALUE);

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_wr_en;
    logic [rti_pkg::NCOLS_W-1:0]   cfg_wr_data;

    rti_req_if req_ch ();
    rti_rsp_if rsp_ch ();

    row_table_insert_remove dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    // Predicted table contents, row count and column setting
    logic [TABLE_COLS-1:0][rti_pkg::VAL_W-1:0] table_rows [TABLE_ROWS];
    int                                        rows_held;
    logic [rti_pkg::NCOLS_W-1:0]               ncols_reg;

    rti_pkg::rsp_t pending_responses [$];
    int            mismatch_count;
    int            idle_cycles;

    // Sender and receiver pacing
    bit   sender_steady;
    bit   receiver_steady;
    int   burst_left;
    int   long_stall_cycles;
    int   stall_left;
    int   pattern_mode;
    int   mode_left;
    int   pattern_tick;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int live_cols();
        if (ncols_reg == 0)
            return 1;
        if (ncols_reg > TABLE_COLS)
            return TABLE_COLS;
        return int'(ncols_reg);
    endfunction

    function automatic rti_pkg::rsp_t apply_request(rti_pkg::req_t item);
        rti_pkg::rsp_t              res;
        logic [rti_pkg::VAL_W-1:0]  lane_vals [TABLE_COLS];
        int                         live;
        int                         row;
        int                         col;
        live = live_cols();
        row  = int'(item.row_index);
        col  = int'(item.col_index);
        res  = '0;
        res.status = rti_pkg::ST_OK;
        lane_vals = '{item.value_0, item.value_1, item.value_2, item.value_3,
                      item.value_4, item.value_5, item.value_6, item.value_7};
        case (item.cmd)
            rti_pkg::CMD_INSERT:
            begin
                if (row > rows_held)
                    res.status = rti_pkg::ST_RANGE;
                else if (rows_held >= TABLE_ROWS)
                    res.status = rti_pkg::ST_FULL;
                else
                begin
                    for (int i = rows_held; i > row; i--)
                        table_rows[i] = table_rows[i-1];
                    for (int c = 0; c < TABLE_COLS; c++)
                        table_rows[row][c] = (c < live) ? lane_vals[c] : FILL_BITS;
                    rows_held++;
                end
            end
            rti_pkg::CMD_REMOVE:
            begin
                if (row >= rows_held)
                    res.status = rti_pkg::ST_RANGE;
                else
                begin
                    // The old top row keeps stale data; only the count drops
                    for (int i = row; i + 1 < rows_held; i++)
                        table_rows[i] = table_rows[i+1];
                    rows_held--;
                end
            end
            default:
            begin
                if (row >= rows_held || col >= live)
                    res.status = rti_pkg::ST_RANGE;
                else if (item.cmd == rti_pkg::CMD_READ)
                    res.read_value = table_rows[row][col];
                else
                    table_rows[row][col] = item.value_0;
            end
        endcase
        res.row_count = rows_held[rti_pkg::ROW_W-1:0];
        return res;
    endfunction

    function automatic logic [rti_pkg::VAL_W-1:0] random_value();
        case ($urandom_range(0, 15))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            4:       return FILL_BITS;
            default: return $urandom;
        endcase
    endfunction

    function automatic rti_pkg::req_t build_request(rti_pkg::cmd_t cmd, int row, int col);
        rti_pkg::req_t item;
        item.cmd       = cmd;
        item.row_index = row[rti_pkg::ROW_W-1:0];
        item.col_index = col[rti_pkg::COL_W-1:0];
        item.value_0   = random_value();
        item.value_1   = random_value();
        item.value_2   = random_value();
        item.value_3   = random_value();
        item.value_4   = random_value();
        item.value_5   = random_value();
        item.value_6   = random_value();
        item.value_7   = random_value();
        return item;
    endfunction

    // Mostly well-formed requests; the row and the column are each arbitrary one time in ten
    function automatic rti_pkg::req_t random_request(int ins_pct, int rem_pct);
        int            pick;
        int            row;
        int            col;
        rti_pkg::cmd_t cmd;
        pick = $urandom_range(0, 99);
        if (pick < ins_pct)
            cmd = rti_pkg::CMD_INSERT;
        else if (pick < ins_pct + rem_pct)
            cmd = rti_pkg::CMD_REMOVE;
        else if ($urandom_range(0, 1) == 0)
            cmd = rti_pkg::CMD_READ;
        else
            cmd = rti_pkg::CMD_WRITE;
        if ($urandom_range(0, 9) == 0)
            row = $urandom_range(0, 127);
        else if (cmd == rti_pkg::CMD_INSERT)
            row = $urandom_range(0, rows_held);
        else if (rows_held > 0)
            row = $urandom_range(0, rows_held - 1);
        else
            row = 0;
        if ($urandom_range(0, 9) == 0)
            col = $urandom_range(0, 7);
        else
            col = $urandom_range(0, live_cols() - 1);
        return build_request(cmd, row, col);
    endfunction

    task automatic send_request(input rti_pkg::req_t item);
        int gap;
        if (!sender_steady)
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
                burst_left = $urandom_range(1, 16);
                repeat (gap)
                begin
                    @(negedge clk);
                    req_ch.valid <= 1'b0;
                end
            end
            burst_left--;
        end
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_responses = {pending_responses, apply_request(item)};
    endtask

    task automatic release_request();
        @(negedge clk);
        req_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_responses.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_ncols(input logic [rti_pkg::NCOLS_W-1:0] value);
        release_request();
        wait_drained();
        repeat (6) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        ncols_reg = value;
    endtask

    task automatic test_directed();
        rti_pkg::req_t item;
        send_request(build_request(rti_pkg::CMD_READ, 0, 0));
        send_request(build_request(rti_pkg::CMD_REMOVE, 0, 0));
        send_request(build_request(rti_pkg::CMD_WRITE, 0, 0));
        send_request(build_request(rti_pkg::CMD_INSERT, 1, 0));
        item = build_request(rti_pkg::CMD_INSERT, 0, 0);
        item.value_0 = 32'h7fff_ffff;
        item.value_1 = 32'h8000_0000;
        item.value_2 = 32'h0000_0000;
        item.value_3 = 32'hffff_ffff;
        item.value_4 = 32'h0000_0001;
        item.value_5 = 32'hffff_fffd;
        item.value_6 = 32'h5555_5555;
        item.value_7 = 32'haaaa_aaaa;
        send_request(item);
        send_request(build_request(rti_pkg::CMD_INSERT, 1, 0));
        send_request(build_request(rti_pkg::CMD_INSERT, 0, 0));
        send_request(build_request(rti_pkg::CMD_INSERT, 1, 0));
        send_request(build_request(rti_pkg::CMD_READ, 2, 0));
        send_request(build_request(rti_pkg::CMD_READ, 2, 1));
        send_request(build_request(rti_pkg::CMD_READ, 2, 7));
        item = build_request(rti_pkg::CMD_WRITE, 2, 7);
        item.value_0 = 32'h8000_0000;
        send_request(item);
        send_request(build_request(rti_pkg::CMD_READ, 2, 7));
        item = build_request(rti_pkg::CMD_WRITE, 0, 0);
        item.value_0 = 32'h7fff_ffff;
        send_request(item);
        send_request(build_request(rti_pkg::CMD_READ, 4, 0));
        send_request(build_request(rti_pkg::CMD_READ, 127, 0));
        send_request(build_request(rti_pkg::CMD_INSERT, 64, 0));
        send_request(build_request(rti_pkg::CMD_REMOVE, 1, 0));
        send_request(build_request(rti_pkg::CMD_REMOVE, 2, 0));
        send_request(build_request(rti_pkg::CMD_READ, 1, 1));
        send_request(build_request(rti_pkg::CMD_REMOVE, 0, 0));
        send_request(build_request(rti_pkg::CMD_READ, 0, 3));
    endtask

    task automatic test_column_limits();
        write_ncols(4'd3);
        send_request(build_request(rti_pkg::CMD_INSERT, 0, 0));
        send_request(build_request(rti_pkg::CMD_READ, 0, 2));
        send_request(build_request(rti_pkg::CMD_READ, 0, 3));
        send_request(build_request(rti_pkg::CMD_WRITE, 0, 5));
        // Dead lanes of the new row come back as fill once they are live
        write_ncols(4'd8);
        send_request(build_request(rti_pkg::CMD_READ, 0, 3));
        send_request(build_request(rti_pkg::CMD_READ, 0, 7));
        write_ncols(4'd0);
        send_request(build_request(rti_pkg::CMD_READ, 0, 0));
        send_request(build_request(rti_pkg::CMD_READ, 0, 1));
        send_request(build_request(rti_pkg::CMD_WRITE, 0, 0));
        send_request(build_request(rti_pkg::CMD_INSERT, 0, 0));
        write_ncols(4'd15);
        send_request(build_request(rti_pkg::CMD_READ, 0, 7));
        send_request(build_request(rti_pkg::CMD_READ, 0, 5));
        send_request(build_request(rti_pkg::CMD_READ, 1, 0));
    endtask

    task automatic test_fill_and_drain();
        write_ncols(4'($urandom_range(1, 8)));
        while (rows_held < TABLE_ROWS)
        begin
            send_request(build_request(rti_pkg::CMD_INSERT, $urandom_range(0, rows_held), 0));
            if ($urandom_range(0, 2) == 0)
                send_request(build_request(rti_pkg::CMD_READ, $urandom_range(0, rows_held - 1),
                                           $urandom_range(0, live_cols() - 1)));
        end
        send_request(build_request(rti_pkg::CMD_INSERT, 0, 0));
        send_request(build_request(rti_pkg::CMD_INSERT, TABLE_ROWS, 0));
        // Range check wins over the full check
        send_request(build_request(rti_pkg::CMD_INSERT, TABLE_ROWS + 1, 0));
        send_request(build_request(rti_pkg::CMD_READ, TABLE_ROWS - 1, 0));
        send_request(build_request(rti_pkg::CMD_WRITE, TABLE_ROWS - 1, live_cols() - 1));
        send_request(build_request(rti_pkg::CMD_READ, TABLE_ROWS - 1, live_cols() - 1));
        while (rows_held > 0)
        begin
            send_request(build_request(rti_pkg::CMD_REMOVE, $urandom_range(0, rows_held - 1), 0));
            if (rows_held > 0 && $urandom_range(0, 2) == 0)
                send_request(build_request(rti_pkg::CMD_READ, $urandom_range(0, rows_held - 1),
                                           $urandom_range(0, live_cols() - 1)));
        end
        send_request(build_request(rti_pkg::CMD_REMOVE, 0, 0));
    endtask

    task automatic test_backpressure();
        sender_steady = 1'b1;
        long_stall_cycles = 400;
        repeat (30)
            send_request(random_request(40, 20));
        sender_steady = 1'b0;
    endtask

    task automatic test_random();
        logic [rti_pkg::NCOLS_W-1:0] phase_ncols [8];
        int                          ins_pct;
        int                          rem_pct;
        phase_ncols = '{4'd1, 4'd8, 4'd5, 4'd0, 4'd15, 4'd2, 4'd12, 4'($urandom_range(1, 8))};
        for (int p = 0; p < 8; p++)
        begin
            write_ncols(phase_ncols[p]);
            sender_steady   = (p % 4 == 1);
            receiver_steady = (p % 4 == 2);
            // Alternate between growing the table and shrinking it
            ins_pct = (p % 2 == 0) ? 50 : 20;
            rem_pct = (p % 2 == 0) ? 15 : 40;
            repeat (150)
                send_request(random_request(ins_pct, rem_pct));
        end
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
    endtask

    // Receiver: pattern of stalls plus the long hold-off on request
    initial
    begin
        rsp_ch.ready = 1'b0;
        stall_left   = 0;
        mode_left    = 0;
        pattern_tick = 0;
        forever
        begin
            @(negedge clk);
            if (long_stall_cycles > 0)
            begin
                stall_left = long_stall_cycles;
                long_stall_cycles = 0;
            end
            pattern_tick++;
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (receiver_steady)
                rsp_ch.ready <= 1'b1;
            else
            begin
                if (mode_left == 0)
                begin
                    pattern_mode = $urandom_range(0, 3);
                    mode_left    = $urandom_range(20, 150);
                end
                mode_left--;
                case (pattern_mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= ($urandom_range(0, 99) < 70);
                    2:       rsp_ch.ready <= (pattern_tick % 5 != 0);
                    default: rsp_ch.ready <= (pattern_tick % 23 >= 8);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : check_responses
        rti_pkg::rsp_t want;
        rti_pkg::rsp_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = rsp_ch.data;
            if (pending_responses.size() == 0)
            begin
                $display("%0t: unexpected response: read_value %0d status %0d row_count %0d",
                         $time, got.read_value, got.status, got.row_count);
                mismatch_count++;
            end
            else
            begin
                want = pending_responses.pop_front();
                if (got.read_value !== want.read_value)
                begin
                    $display("%0t: read_value mismatch: expected %0d, actual %0d",
                             $time, want.read_value, got.read_value);
                    mismatch_count++;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, got.status);
                    mismatch_count++;
                end
                if (got.row_count !== want.row_count)
                begin
                    $display("%0t: row_count mismatch: expected %0d, actual %0d",
                             $time, want.row_count, got.row_count);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run if no request or response moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("row_table_insert_remove test failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        req_ch.valid      = 1'b0;
        req_ch.data       = '0;
        mismatch_count    = 0;
        idle_cycles       = 0;
        sender_steady     = 1'b0;
        receiver_steady   = 1'b0;
        burst_left        = 0;
        long_stall_cycles = 0;
        rows_held         = 0;
        ncols_reg         = 4'(TABLE_COLS);
        for (int r = 0; r < TABLE_ROWS; r++)
            for (int c = 0; c < TABLE_COLS; c++)
                table_rows[r][c] = FILL_BITS;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_column_limits();
        test_fill_and_drain();
        test_backpressure();
        test_random();

        release_request();
        wait_drained();
        repeat (SETTLE_WAIT) @(posedge clk);
        if (mismatch_count == 0)
            $display("row_table_insert_remove test passed");
        else
            $display("row_table_insert_remove test failed");
        $finish;
    end

endmodule
